/* src/ikp_pkg.sv */
package ikp_pkg;

   typedef enum logic [1:0] {
      REQ_TICK,
      REQ_WRITE,
      REQ_READ,
      REQ_POLL
   } req_kind_type;

   typedef struct packed {
      req_kind_type req_type;
      logic [7:0]   reg_addr;
      logic [7:0]   wr_data;
      logic         sda_in;
   } req_item_type;

   typedef struct packed {
      logic        scl;
      logic        sda_out;
      logic        sda_listen;
      logic        busy_res;
      logic        done_res;
      logic [15:0] read_data;
      logic [6:0]  key_code;
   } rsp_item_type;

   typedef struct packed {
      logic [6:0] device_address;
      logic [7:0] sensor_register;
      logic [7:0] reset_period;
      logic [7:0] reset_register;
      logic [7:0] reset_value;
   } csr_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEVICE_ADDRESS,
      CSR_SENSOR_REGISTER,
      CSR_RESET_PERIOD,
      CSR_RESET_REGISTER,
      CSR_RESET_VALUE
   } csr_index_type;

   localparam logic [6:0] DEVICE_ADDRESS_RST  = 7'd112;
   localparam logic [7:0] SENSOR_REGISTER_RST = 8'h08;
   localparam logic [7:0] RESET_PERIOD_RST    = 8'd200;
   localparam logic [7:0] RESET_REGISTER_RST  = 8'h00;
   localparam logic [7:0] RESET_VALUE_RST     = 8'h6A;

   typedef enum logic [2:0] {
      OP_START,
      OP_WR,
      OP_ACK,
      OP_NACK,
      OP_STOP,
      OP_RSU,
      OP_RD
   } op_type;

   typedef enum logic [2:0] {
      ARG_NONE,
      ARG_DEVW,
      ARG_DEVR,
      ARG_ZERO,
      ARG_ADDR,
      ARG_DATA
   } arg_type;

   localparam logic [4:0] STEP_IDLE       = 5'd0;
   localparam logic [4:0] STEP_WRITE      = 5'd1;
   localparam logic [4:0] STEP_WRITE_STOP = 5'd10;
   localparam logic [4:0] STEP_READ       = 5'd11;
   localparam logic [4:0] STEP_BRANCH     = 5'd23;
   localparam logic [4:0] STEP_READ_TAIL  = 5'd24;
   localparam logic [4:0] STEP_POLL_TAIL  = 5'd26;
   localparam logic [4:0] STEP_COUNT      = 5'd31;

   typedef struct packed {
      op_type     op;
      arg_type    arg;
      logic [4:0] next;
   } prog_entry_type;

   localparam int KEY_COUNT = 20;

   localparam logic [15:0] KEY_PAT [KEY_COUNT] = '{
      16'h0404, 16'h0082, 16'h0084, 16'h0088, 16'h0102, 16'h0104, 16'h0108,
      16'h0202, 16'h0204, 16'h0208, 16'h0402, 16'h0408, 16'h0090, 16'h0110,
      16'h0210, 16'h00A0, 16'h0120, 16'h0220, 16'h0410, 16'h0420
   };

   localparam logic [6:0] KEY_CHR [KEY_COUNT] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39,
      7'h2A, 7'h23, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h55, 7'h4E
   };

   function automatic prog_entry_type prog_lookup(input logic [4:0] step);
      prog_entry_type e;
      case (step)
         5'd1:    e = '{OP_START, ARG_NONE, 5'd2};
         5'd2:    e = '{OP_WR,    ARG_DEVW, 5'd3};
         5'd3:    e = '{OP_ACK,   ARG_NONE, 5'd4};
         5'd4:    e = '{OP_WR,    ARG_ZERO, 5'd5};
         5'd5:    e = '{OP_ACK,   ARG_NONE, 5'd6};
         5'd6:    e = '{OP_WR,    ARG_ADDR, 5'd7};
         5'd7:    e = '{OP_ACK,   ARG_NONE, 5'd8};
         5'd8:    e = '{OP_WR,    ARG_DATA, 5'd9};
         5'd9:    e = '{OP_ACK,   ARG_NONE, 5'd10};
         5'd10:   e = '{OP_STOP,  ARG_NONE, 5'd0};
         5'd11:   e = '{OP_START, ARG_NONE, 5'd12};
         5'd12:   e = '{OP_WR,    ARG_DEVW, 5'd13};
         5'd13:   e = '{OP_ACK,   ARG_NONE, 5'd14};
         5'd14:   e = '{OP_WR,    ARG_ZERO, 5'd15};
         5'd15:   e = '{OP_ACK,   ARG_NONE, 5'd16};
         5'd16:   e = '{OP_WR,    ARG_ADDR, 5'd17};
         5'd17:   e = '{OP_ACK,   ARG_NONE, 5'd18};
         5'd18:   e = '{OP_STOP,  ARG_NONE, 5'd19};
         5'd19:   e = '{OP_START, ARG_NONE, 5'd20};
         5'd20:   e = '{OP_WR,    ARG_DEVR, 5'd21};
         5'd21:   e = '{OP_ACK,   ARG_NONE, 5'd22};
         5'd22:   e = '{OP_RSU,   ARG_NONE, 5'd23};
         5'd23:   e = '{OP_RD,    ARG_NONE, 5'd0};
         5'd24:   e = '{OP_NACK,  ARG_NONE, 5'd25};
         5'd25:   e = '{OP_STOP,  ARG_NONE, 5'd0};
         5'd26:   e = '{OP_ACK,   ARG_NONE, 5'd27};
         5'd27:   e = '{OP_RSU,   ARG_NONE, 5'd28};
         5'd28:   e = '{OP_RD,    ARG_NONE, 5'd29};
         5'd29:   e = '{OP_NACK,  ARG_NONE, 5'd30};
         5'd30:   e = '{OP_STOP,  ARG_NONE, 5'd0};
         default: e = '{OP_STOP,  ARG_NONE, 5'd0};
      endcase
      return e;
   endfunction

   function automatic logic [3:0] op_last(input op_type op);
      logic [3:0] n;
      case (op)
         OP_START: n = 4'd2;
         OP_WR:    n = 4'd15;
         OP_ACK:   n = 4'd1;
         OP_NACK:  n = 4'd1;
         OP_STOP:  n = 4'd2;
         OP_RSU:   n = 4'd0;
         OP_RD:    n = 4'd15;
         default:  n = 4'd0;
      endcase
      return n;
   endfunction

endpackage

/* src/ikp_csr.sv */
module ikp_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [ikp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ikp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output ikp_pkg::csr_type                   csr
);
   import ikp_pkg::*;

   csr_type csr_ff;
   csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS:  csr_in.device_address  = csr_wdata[6:0];
            CSR_SENSOR_REGISTER: csr_in.sensor_register = csr_wdata;
            CSR_RESET_PERIOD:    csr_in.reset_period    = csr_wdata;
            CSR_RESET_REGISTER:  csr_in.reset_register  = csr_wdata;
            CSR_RESET_VALUE:     csr_in.reset_value     = csr_wdata;
            default:             csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.device_address  <= DEVICE_ADDRESS_RST;
         csr_ff.sensor_register <= SENSOR_REGISTER_RST;
         csr_ff.reset_period    <= RESET_PERIOD_RST;
         csr_ff.reset_register  <= RESET_REGISTER_RST;
         csr_ff.reset_value     <= RESET_VALUE_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

/* src/ikp_key_decode.sv */
module ikp_key_decode (
   input  logic [15:0] pattern,
   output logic [6:0]  key
);
   import ikp_pkg::*;

   always_comb begin
      key = '0;
      for (int i = 0; i < KEY_COUNT; i++) begin
         if (pattern == KEY_PAT[i]) begin
            key = key | KEY_CHR[i];
         end
      end
   end

endmodule

/* src/ikp_sequencer.sv */
module ikp_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  ikp_pkg::req_item_type item,
   input  ikp_pkg::csr_type      csr,
   output ikp_pkg::rsp_item_type result
);
   import ikp_pkg::*;

   logic [4:0]   step_ff, step_in;
   logic [3:0]   bit_ff, bit_in;
   logic [7:0]   shift_ff, shift_in;
   logic [15:0]  acc_ff, acc_in;
   logic [7:0]   count_ff, count_in;
   req_kind_type kind_ff, kind_in;
   logic [7:0]   addr_ff, addr_in;
   logic [7:0]   data_ff, data_in;
   logic [6:0]   key_ff, key_in;

   logic [6:0]     key_dec;
   prog_entry_type entry;
   logic [3:0]     bi;
   logic [7:0]     operand;
   logic [7:0]     shift_cur;
   logic [7:0]     count_inc;
   logic [4:0]     nxt;

   // acc is unchanged on the final STOP of a poll, so decode the stored value
   ikp_key_decode u_key_decode (
      .pattern (acc_ff),
      .key     (key_dec)
   );

   always_comb begin
      step_in   = (step_ff == STEP_COUNT) ? STEP_IDLE : step_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      acc_in    = acc_ff;
      count_in  = count_ff;
      kind_in   = kind_ff;
      addr_in   = addr_ff;
      data_in   = data_ff;
      key_in    = key_ff;
      entry     = prog_lookup(STEP_IDLE);
      bi        = '0;
      operand   = '0;
      shift_cur = shift_ff;
      count_inc = count_ff + 8'd1;
      nxt       = STEP_IDLE;

      result.scl        = 1'b1;
      result.sda_out    = 1'b1;
      result.sda_listen = 1'b0;
      result.busy_res   = 1'b0;
      result.done_res   = 1'b0;

      // take a new request only while idle
      if (step_in == STEP_IDLE && item.req_type != REQ_TICK) begin
         kind_in = item.req_type;
         bit_in  = '0;
         data_in = item.wr_data;
         if (item.req_type == REQ_WRITE) begin
            step_in = STEP_WRITE;
            addr_in = item.reg_addr;
         end else begin
            step_in = STEP_READ;
            acc_in  = '0;
            addr_in = (item.req_type == REQ_READ) ? item.reg_addr : csr.sensor_register;
         end
      end

      if (step_in != STEP_IDLE) begin
         entry = prog_lookup(step_in);
         bi    = bit_in;
         result.busy_res = 1'b1;

         case (entry.arg)
            ARG_DEVW: operand = {csr.device_address, 1'b0};
            ARG_DEVR: operand = {csr.device_address, 1'b1};
            ARG_ADDR: operand = addr_in;
            ARG_DATA: operand = data_in;
            default:  operand = '0;
         endcase

         case (entry.op)
            OP_START: begin
               result.scl     = (bi < 4'd2);
               result.sda_out = (bi == 4'd0);
            end
            OP_WR: begin
               shift_cur      = (bi == 4'd0) ? operand : shift_ff;
               result.sda_out = shift_cur[7];
               result.scl     = ~bi[0];
               shift_in       = bi[0] ? {shift_cur[6:0], 1'b0} : shift_cur;
            end
            OP_ACK: begin
               result.sda_out = 1'b0;
               result.scl     = (bi == 4'd0);
            end
            OP_NACK: begin
               result.sda_out = 1'b1;
               result.scl     = (bi == 4'd0);
            end
            OP_STOP: begin
               result.scl     = (bi != 4'd0);
               result.sda_out = (bi == 4'd2);
            end
            OP_RSU: begin
               result.scl        = 1'b0;
               result.sda_out    = 1'b1;
               result.sda_listen = 1'b1;
            end
            OP_RD: begin
               result.sda_out    = 1'b1;
               result.sda_listen = 1'b1;
               result.scl        = ~bi[0];
               if (!bi[0]) begin
                  acc_in = {acc_in[14:0], item.sda_in};
               end
            end
            default: begin
               result.scl     = 1'b1;
               result.sda_out = 1'b1;
            end
         endcase

         if (bi != op_last(entry.op)) begin
            bit_in = bi + 4'd1;
         end else begin
            bit_in = '0;
            nxt    = entry.next;
            if (step_in == STEP_BRANCH) begin
               nxt = (kind_in == REQ_POLL) ? STEP_POLL_TAIL : STEP_READ_TAIL;
            end
            if (nxt != STEP_IDLE) begin
               step_in = nxt;
            end else if (kind_in == REQ_POLL && step_in != STEP_WRITE_STOP) begin
               key_in = key_dec;
               if (count_inc > csr.reset_period) begin
                  count_in = '0;
                  addr_in  = csr.reset_register;
                  data_in  = csr.reset_value;
                  step_in  = STEP_WRITE;
               end else begin
                  count_in        = count_inc;
                  step_in         = STEP_IDLE;
                  result.done_res = 1'b1;
               end
            end else begin
               step_in         = STEP_IDLE;
               result.done_res = 1'b1;
            end
         end
      end

      result.read_data = acc_in;
      result.key_code  = key_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_IDLE;
         bit_ff   <= '0;
         shift_ff <= '0;
         acc_ff   <= '0;
         count_ff <= '0;
         kind_ff  <= REQ_TICK;
         addr_ff  <= '0;
         data_ff  <= '0;
         key_ff   <= '0;
      end else if (step_en) begin
         step_ff  <= step_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         acc_ff   <= acc_in;
         count_ff <= count_in;
         kind_ff  <= kind_in;
         addr_ff  <= addr_in;
         data_ff  <= data_in;
         key_ff   <= key_in;
      end
   end

endmodule

/* src/i2c_keypad_poller_top.sv */
// Channel  Direction  Ports                          Item
// req      in         req_valid req_ready req_data   one bit-timing interval
// rsp      out        rsp_valid rsp_ready rsp_data   bus levels and status
// csr      in         csr_we csr_index csr_wdata     register write, no wait
//
// One item per cycle sustained while rsp is not stalled; an accepted item sits
// in the input register while the sequencer step settles, and the result
// register takes it as it leaves, raising rsp_valid. Sequencer state
// moves only as an item leaves the input register. A stalled rsp holds the
// result; the input register still takes one more item. Reset is synchronous,
// clears all sequencer state and returns the CSRs to their defaults.
module i2c_keypad_poller_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  ikp_pkg::req_item_type           req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output ikp_pkg::rsp_item_type           rsp_data,
   input  logic                            csr_we,
   input  logic [ikp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ikp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ikp_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;

   logic         advance;
   csr_type      csr;
   rsp_item_type step_result;

   ikp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr       (csr)
   );

   ikp_sequencer u_sequencer (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .csr     (csr),
      .result  (step_result)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

endmodule
